// ===== hdl/gdbo_pkg.sv =====
// ----------------------------------------------------------------------------
// gdbo_pkg: shared types and constants of the graph walker
// Field widths, operation and status codes, and the front to back item record.
// ----------------------------------------------------------------------------
`default_nettype none

package gdbo_pkg;

  localparam int NODE_W = 7;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_EDGES_DEF = 1024;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_DFS = 2'd1;
  localparam logic [OP_W-1:0] OP_BFS = 2'd2;

  localparam logic [ST_W-1:0] ST_WALK   = 2'd0;
  localparam logic [ST_W-1:0] ST_STORED = 2'd1;
  localparam logic [ST_W-1:0] ST_DROP   = 2'd2;

  typedef enum logic [1:0] {
    K_ADD,
    K_BAD,
    K_DFS,
    K_BFS
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/gdbo_front.sv =====
// ----------------------------------------------------------------------------
// gdbo_front: command intake
// Checks and classifies commands and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gdbo_front #(
  parameter int MAX_NODES = gdbo_pkg::MAX_NODES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [gdbo_pkg::OP_W-1:0]   operation_i,
  input  wire logic [gdbo_pkg::NODE_W-1:0] node_a_i,
  input  wire logic [gdbo_pkg::NODE_W-1:0] node_b_i,
  output      gdbo_pkg::cmd_t              cmd_o,
  input  wire logic                        pop_i
);
  import gdbo_pkg::*;

  item_t      ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       a_ok, b_ok, keep, push;
  item_t      item;

  assign a_ok = (node_a_i != '0) && (node_a_i <= NODE_W'(MAX_NODES));
  assign b_ok = (node_b_i != '0) && (node_b_i <= NODE_W'(MAX_NODES));

  always_comb begin
    item.node_a = node_a_i;
    item.node_b = node_b_i;
    item.kind   = K_BAD;
    keep        = 1'b0;
    case (operation_i)
      OP_ADD: begin
        keep      = 1'b1;
        item.kind = (a_ok && b_ok) ? K_ADD : K_BAD;
      end
      OP_DFS: begin
        keep      = a_ok;
        item.kind = K_DFS;
      end
      OP_BFS: begin
        keep      = a_ok;
        item.kind = K_BFS;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy && keep;

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  assign cmd_o.vld  = (cnt_q != 2'd0);
  assign cmd_o.item = ent_q[rp_q];

endmodule

`default_nettype wire

// ===== hdl/gdbo_back.sv =====
// ----------------------------------------------------------------------------
// gdbo_back: graph store and walk engine
// Edge store, list heads, walk stack/queue and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gdbo_back #(
  parameter int MAX_NODES = gdbo_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = gdbo_pkg::MAX_EDGES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire gdbo_pkg::cmd_t              cmd_i,
  output      logic                        pop_o,
  output      logic                        valid_o,
  output      logic [gdbo_pkg::NODE_W-1:0] node_o,
  output      logic [gdbo_pkg::ST_W-1:0]   status_o,
  output      logic                        last_o
);
  import gdbo_pkg::*;

  localparam int NIW = $clog2(MAX_NODES + 1);
  localparam int EPW = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int SAW = $clog2(MAX_NODES);
  localparam int SCW = $clog2(MAX_NODES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_DTOP, S_DHEAD, S_BPOP, S_BHEAD, S_LH, S_EDGE, S_DDEC, S_SCAN, S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [SCW-1:0]       sp_q, sp_d, head_q, head_d;
  logic [EPW-1:0]       cnt_q, cnt_d;
  logic [NIW-1:0]       best_q, best_d, scan_q, scan_d, hold_q, hold_d;
  logic                 dfs_q, dfs_d, hold_vld_q, hold_vld_d;
  logic [MAX_NODES:0]   vis_q, vis_d, pend_q, pend_d;
  logic [NIW-1:0]       add_a_q, add_a_d, add_b_q, add_b_d;
  logic                 valid_q, valid_d, last_q, last_d;
  logic [NIW-1:0]       node_q, node_d;
  logic [ST_W-1:0]      status_q, status_d;

  // memories
  logic [NIW+EPW-1:0]   emem [MAX_EDGES];
  logic [NIW+EPW-1:0]   erd_q;
  logic [EPW-1:0]       lmem [MAX_NODES+1];
  logic [EPW-1:0]       lrd_q;
  logic                 lrv_q;
  logic [MAX_NODES:0]   lvld_q;
  logic [NIW-1:0]       wmem [MAX_NODES];
  logic [NIW-1:0]       wrd_q;

  logic                 e_we, l_we, w_we;
  logic [EAW-1:0]       e_raddr, e_waddr;
  logic [NIW+EPW-1:0]   e_wdata;
  logic [NIW-1:0]       l_raddr, l_waddr;
  logic [EPW-1:0]       l_wdata;
  logic [SAW-1:0]       w_raddr, w_waddr;
  logic [NIW-1:0]       w_wdata;

  logic [EPW-1:0]       lh_head, lh_m1, e_nxt, nxt_m1;
  logic [NIW-1:0]       e_tgt, a_in, b_in;
  logic [SCW-1:0]       sp_m1;
  logic                 visit_en;
  logic [NIW-1:0]       visit_node;

  assign lh_head = lrv_q ? lrd_q : '0;
  assign lh_m1   = lh_head - EPW'(1);
  assign e_tgt   = erd_q[NIW+EPW-1:EPW];
  assign e_nxt   = erd_q[EPW-1:0];
  assign nxt_m1  = e_nxt - EPW'(1);
  assign sp_m1   = sp_q - SCW'(1);
  assign a_in    = cmd_i.item.node_a[NIW-1:0];
  assign b_in    = cmd_i.item.node_b[NIW-1:0];

  always_comb begin
    state_d    = state_q;
    sp_d       = sp_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    best_d     = best_q;
    scan_d     = scan_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    dfs_d      = dfs_q;
    vis_d      = vis_q;
    pend_d     = pend_q;
    add_a_d    = add_a_q;
    add_b_d    = add_b_q;
    valid_d    = 1'b0;
    last_d     = 1'b0;
    node_d     = node_q;
    status_d   = ST_WALK;
    pop_o      = 1'b0;
    e_we       = 1'b0;
    l_we       = 1'b0;
    w_we       = 1'b0;
    e_raddr    = '0;
    e_waddr    = '0;
    e_wdata    = '0;
    l_raddr    = '0;
    l_waddr    = '0;
    l_wdata    = '0;
    w_raddr    = '0;
    w_waddr    = '0;
    w_wdata    = '0;
    visit_en   = 1'b0;
    visit_node = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.vld) begin
          pop_o = 1'b1;
          case (cmd_i.item.kind)
            K_ADD: begin
              if (cnt_q == EPW'(MAX_EDGES)) begin
                valid_d  = 1'b1;
                node_d   = '0;
                status_d = ST_DROP;
                last_d   = 1'b1;
              end else begin
                add_a_d = a_in;
                add_b_d = b_in;
                l_raddr = a_in;
                state_d = S_ADD;
              end
            end
            K_DFS, K_BFS: begin
              vis_d       = '0;
              vis_d[a_in] = 1'b1;
              w_we        = 1'b1;
              w_waddr     = '0;
              w_wdata     = a_in;
              sp_d        = SCW'(1);
              head_d      = '0;
              if (cmd_i.item.kind == K_DFS) begin
                dfs_d      = 1'b1;
                visit_en   = 1'b1;
                visit_node = a_in;
                state_d    = S_DTOP;
              end else begin
                dfs_d   = 1'b0;
                state_d = S_BPOP;
              end
            end
            default: begin
              valid_d  = 1'b1;
              node_d   = '0;
              status_d = ST_DROP;
              last_d   = 1'b1;
            end
          endcase
        end
      end
      S_ADD: begin
        e_we     = 1'b1;
        e_waddr  = cnt_q[EAW-1:0];
        e_wdata  = {add_b_q, lh_head};
        l_we     = 1'b1;
        l_waddr  = add_a_q;
        l_wdata  = cnt_q + EPW'(1);
        cnt_d    = cnt_q + EPW'(1);
        valid_d  = 1'b1;
        node_d   = '0;
        status_d = ST_STORED;
        last_d   = 1'b1;
        state_d  = S_IDLE;
      end
      S_DTOP: begin
        if (sp_q == '0) begin
          state_d = S_DONE;
        end else begin
          w_raddr = sp_m1[SAW-1:0];
          state_d = S_DHEAD;
        end
      end
      S_DHEAD: begin
        l_raddr = wrd_q;
        best_d  = '0;
        state_d = S_LH;
      end
      S_BPOP: begin
        if (head_q == sp_q) begin
          state_d = S_DONE;
        end else begin
          w_raddr = head_q[SAW-1:0];
          head_d  = head_q + SCW'(1);
          state_d = S_BHEAD;
        end
      end
      S_BHEAD: begin
        visit_en   = 1'b1;
        visit_node = wrd_q;
        l_raddr    = wrd_q;
        pend_d     = '0;
        state_d    = S_LH;
      end
      S_LH: begin
        if (lh_head == '0) begin
          scan_d  = NIW'(1);
          state_d = dfs_q ? S_DDEC : S_SCAN;
        end else begin
          e_raddr = lh_m1[EAW-1:0];
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        if (dfs_q) begin
          if (!vis_q[e_tgt] && (best_q == '0 || e_tgt < best_q)) best_d = e_tgt;
        end else if (!vis_q[e_tgt]) begin
          vis_d[e_tgt]  = 1'b1;
          pend_d[e_tgt] = 1'b1;
        end
        if (e_nxt != '0) begin
          e_raddr = nxt_m1[EAW-1:0];
        end else begin
          scan_d  = NIW'(1);
          state_d = dfs_q ? S_DDEC : S_SCAN;
        end
      end
      S_DDEC: begin
        if (best_q != '0) begin
          vis_d[best_q] = 1'b1;
          visit_en      = 1'b1;
          visit_node    = best_q;
          w_we          = 1'b1;
          w_waddr       = sp_q[SAW-1:0];
          w_wdata       = best_q;
          sp_d          = sp_q + SCW'(1);
        end else begin
          sp_d = sp_m1;
        end
        state_d = S_DTOP;
      end
      S_SCAN: begin
        if (pend_q[scan_q]) begin
          w_we    = 1'b1;
          w_waddr = sp_q[SAW-1:0];
          w_wdata = scan_q;
          sp_d    = sp_q + SCW'(1);
        end
        if (scan_q == NIW'(MAX_NODES)) state_d = S_BPOP;
        else scan_d = scan_q + NIW'(1);
      end
      S_DONE: begin
        valid_d    = 1'b1;
        node_d     = hold_q;
        status_d   = ST_WALK;
        last_d     = 1'b1;
        hold_vld_d = 1'b0;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // one-deep hold so the final walk node can carry last
    if (visit_en) begin
      if (hold_vld_q) begin
        valid_d  = 1'b1;
        node_d   = hold_q;
        status_d = ST_WALK;
        last_d   = 1'b0;
      end
      hold_d     = visit_node;
      hold_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      sp_q       <= '0;
      head_q     <= '0;
      cnt_q      <= '0;
      best_q     <= '0;
      scan_q     <= '0;
      hold_q     <= '0;
      hold_vld_q <= 1'b0;
      dfs_q      <= 1'b0;
      vis_q      <= '0;
      pend_q     <= '0;
      add_a_q    <= '0;
      add_b_q    <= '0;
      valid_q    <= 1'b0;
      last_q     <= 1'b0;
      node_q     <= '0;
      status_q   <= ST_WALK;
      lvld_q     <= '0;
    end else begin
      state_q    <= state_d;
      sp_q       <= sp_d;
      head_q     <= head_d;
      cnt_q      <= cnt_d;
      best_q     <= best_d;
      scan_q     <= scan_d;
      hold_q     <= hold_d;
      hold_vld_q <= hold_vld_d;
      dfs_q      <= dfs_d;
      vis_q      <= vis_d;
      pend_q     <= pend_d;
      add_a_q    <= add_a_d;
      add_b_q    <= add_b_d;
      valid_q    <= valid_d;
      last_q     <= last_d;
      node_q     <= node_d;
      status_q   <= status_d;
      if (l_we) lvld_q[l_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_we) emem[e_waddr] <= e_wdata;
    erd_q <= emem[e_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) lmem[l_waddr] <= l_wdata;
    lrd_q <= lmem[l_raddr];
    lrv_q <= lvld_q[l_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    wrd_q <= wmem[w_raddr];
  end

  assign valid_o  = valid_q;
  assign node_o   = NODE_W'(node_q);
  assign status_o = status_q;
  assign last_o   = last_q;

endmodule

`default_nettype wire

// ===== hdl/graph_dfs_bfs_order_top.sv =====
// ----------------------------------------------------------------------------
// graph_dfs_bfs_order_top: directed graph store with depth/breadth-first walks
// Stores directed edges in linked adjacency lists and walks from a start node.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive operation_i/node_a_i/node_b_i with start high; the
//   transfer happens on a rising edge where busy is low. Commands land in a
//   two-entry queue, so busy rises only when that queue is full.
//   Result channel: valid_o strobes one cycle per result (node_o, status_o,
//   last_o). The receiver cannot stall; every result is a transfer.
//   Add edge: one status result; when the engine is idle the command passes
//   the queue, a list-head read and the edge write before the result
//   register. A dropped edge answers straight from the engine's idle state.
//   Walks: one result per visited node, last_o on the final one. Cost is set
//   by the edge memory walk, one edge per cycle: DFS rereads the top node's
//   list on every push and pop step, BFS reads each list once and then scans
//   a bit map of MAX_NODES entries per node.
//   Invalid walk starts and unused op codes are dropped with no result.
//   Reset: empties lists (list-head valid bits) and the edge count; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_dfs_bfs_order_top #(
  parameter int MAX_NODES = gdbo_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = gdbo_pkg::MAX_EDGES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [gdbo_pkg::OP_W-1:0]   operation_i,
  input  wire logic [gdbo_pkg::NODE_W-1:0] node_a_i,
  input  wire logic [gdbo_pkg::NODE_W-1:0] node_b_i,
  output      logic                        valid_o,
  output      logic [gdbo_pkg::NODE_W-1:0] node_o,
  output      logic [gdbo_pkg::ST_W-1:0]   status_o,
  output      logic                        last_o
);
  import gdbo_pkg::*;

  cmd_t cmd;   // queued command toward the engine
  logic pop;   // engine takes the queue head

  gdbo_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operation_i(operation_i),
    .node_a_i   (node_a_i),
    .node_b_i   (node_b_i),
    .cmd_o      (cmd),
    .pop_i      (pop)
  );

  gdbo_back #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .pop_o   (pop),
    .valid_o (valid_o),
    .node_o  (node_o),
    .status_o(status_o),
    .last_o  (last_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_graph_dfs_bfs_order_top.sv =====
// ----------------------------------------------------------------------------
// tb_graph_dfs_bfs_order_top: self-checking bench for the graph walker
// Builds graphs with edge commands, runs DFS/BFS walks, and checks every
// result strobe against an in-bench model of the adjacency store and walks.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_graph_dfs_bfs_order_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gdbo_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int NODES      = MAX_NODES_DEF;
  localparam int EDGES      = MAX_EDGES_DEF;
  localparam int CYCLE_CAP  = 3_000_000;
  localparam int DRAIN_CYC  = 64;

  typedef struct {
    logic [NODE_W-1:0] node;
    logic [ST_W-1:0]   status;
    logic              last;
  } walk_res_t;

  // Graph store model plus the queue of results still owed by the block.
  class graph_scoreboard;
    logic [NODE_W-1:0] tgt [EDGES+1];
    int                link [EDGES+1];
    int                head [NODES+1];
    int                n_edges;
    bit                seen [NODES+1];
    walk_res_t         owed [$];
    int                errors;

    function new();
      n_edges = 0;
      errors  = 0;
      foreach (head[i]) head[i] = 0;
    endfunction

    function automatic bit node_ok(logic [NODE_W-1:0] v);
      return v >= 1 && v <= NODES;
    endfunction

    function automatic void owe(logic [NODE_W-1:0] n, logic [ST_W-1:0] s);
      walk_res_t r;
      r.node = n; r.status = s; r.last = 1'b0;
      owed = {owed, r};
    endfunction

    // smallest unvisited successor of v, 0 if none
    function automatic int least_open(int v);
      int best, e;
      best = 0;
      e = head[v];
      while (e != 0) begin
        if (!seen[tgt[e]] && (best == 0 || tgt[e] < best)) best = tgt[e];
        e = link[e];
      end
      return best;
    endfunction

    function automatic void note_command(logic [OP_W-1:0] op, logic [NODE_W-1:0] a,
                                         logic [NODE_W-1:0] b);
      int stk [$];
      int fifo [$];
      int nbrs [$];
      int owed_start, v, nb, e;
      owed_start = owed.size();
      if (op == OP_ADD) begin
        if (node_ok(a) && node_ok(b) && n_edges < EDGES) begin
          n_edges++;
          tgt[n_edges]  = b;
          link[n_edges] = head[a];
          head[a]       = n_edges;
          owe('0, ST_STORED);
        end else begin
          owe('0, ST_DROP);
        end
      end else if (op == OP_UNUSED || !node_ok(a)) begin
        return;
      end else begin
        foreach (seen[i]) seen[i] = 1'b0;
        seen[a] = 1'b1;
        if (op == OP_DFS) begin
          owe(a, ST_WALK);
          stk = {stk, int'(a)};
          while (stk.size() > 0) begin
            nb = least_open(stk[$]);
            if (nb != 0) begin
              seen[nb] = 1'b1;
              owe(nb[NODE_W-1:0], ST_WALK);
              stk = {stk, nb};
            end else begin
              void'(stk.pop_back());
            end
          end
        end else begin
          fifo = {fifo, int'(a)};
          while (fifo.size() > 0) begin
            v = fifo.pop_front();
            owe(v[NODE_W-1:0], ST_WALK);
            nbrs.delete();
            e = head[v];
            while (e != 0) begin
              if (!seen[tgt[e]]) begin
                seen[tgt[e]] = 1'b1;
                nbrs = {nbrs, int'(tgt[e])};
              end
              e = link[e];
            end
            nbrs.sort();
            foreach (nbrs[i]) fifo = {fifo, nbrs[i]};
          end
        end
      end
      if (owed.size() > owed_start) owed[$].last = 1'b1;
    endfunction

    function automatic void check_result(logic [NODE_W-1:0] n, logic [ST_W-1:0] s,
                                         logic l);
      walk_res_t x;
      if (owed.size() == 0) begin
        $error("unexpected result node=%0d status=%0d last=%0d", n, s, l);
        errors++;
        return;
      end
      x = owed.pop_front();
      if (n !== x.node) begin
        $error("node: expected %0d, got %0d", x.node, n); errors++;
      end
      if (s !== x.status) begin
        $error("status: expected %0d, got %0d", x.status, s); errors++;
      end
      if (l !== x.last) begin
        $error("last: expected %0d, got %0d", x.last, l); errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   operation_i = '0;
  logic [NODE_W-1:0] node_a_i = '0;
  logic [NODE_W-1:0] node_b_i = '0;
  logic              valid_o;
  logic [NODE_W-1:0] node_o;
  logic [ST_W-1:0]   status_o;
  logic              last_o;

  graph_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;

  graph_dfs_bfs_order_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operation_i(operation_i),
    .node_a_i   (node_a_i),
    .node_b_i   (node_b_i),
    .valid_o    (valid_o),
    .node_o     (node_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run guard: a hung walk or lost command ends here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: the block cannot be stalled, so every strobe is a transfer.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(node_o, status_o, last_o);
  end

  // One command transfer. Start stays high across a burst; a gap lowers it
  // and idles a random number of cycles before the next command.
  task automatic send_cmd(logic [OP_W-1:0] op, logic [NODE_W-1:0] a,
                          logic [NODE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start       <= 1'b1;
    operation_i <= op;
    node_a_i    <= a;
    node_b_i    <= b;
    // busy read here is the pre-edge value, so this is the transfer edge
    do @(posedge clk_i); while (busy);
    sb.note_command(op, a, b);
  endtask

  // random node: mostly a small cluster so walks go deep, sometimes anywhere
  function automatic logic [NODE_W-1:0] pick_node();
    case ($urandom_range(0, 9))
      0:       return NODE_W'($urandom_range(0, 127));
      1, 2:    return NODE_W'($urandom_range(1, NODES));
      default: return NODE_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic random_cmd();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12)      send_cmd(OP_ADD, pick_node(), pick_node());
    else if (r < 15) send_cmd(OP_DFS, pick_node(), NODE_W'($urandom_range(0, 127)));
    else if (r < 18) send_cmd(OP_BFS, pick_node(), NODE_W'($urandom_range(0, 127)));
    else             send_cmd(OP_UNUSED, pick_node(), pick_node());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walks on an empty graph, then range edges and bad endpoints
    send_cmd(OP_DFS, 7'd1, 7'd0);
    send_cmd(OP_BFS, 7'd64, 7'd127);
    send_cmd(OP_ADD, 7'd1, 7'd64);
    send_cmd(OP_ADD, 7'd64, 7'd1);
    send_cmd(OP_ADD, 7'd0, 7'd5);
    send_cmd(OP_ADD, 7'd5, 7'd0);
    send_cmd(OP_ADD, 7'd65, 7'd3);
    send_cmd(OP_ADD, 7'd127, 7'd127);
    send_cmd(OP_ADD, 7'd3, 7'd3);     // self loop
    send_cmd(OP_ADD, 7'd1, 7'd3);
    send_cmd(OP_ADD, 7'd1, 7'd3);     // duplicate
    send_cmd(OP_ADD, 7'd1, 7'd2);
    send_cmd(OP_ADD, 7'd2, 7'd64);
    send_cmd(OP_ADD, 7'd3, 7'd2);
    send_cmd(OP_UNUSED, 7'd1, 7'd2);  // ignored op code
    send_cmd(OP_DFS, 7'd0, 7'd0);     // bad start, no results
    send_cmd(OP_BFS, 7'd65, 7'd0);
    send_cmd(OP_DFS, 7'd127, 7'd0);
    send_cmd(OP_DFS, 7'd1, 7'd0);
    send_cmd(OP_BFS, 7'd1, 7'd0);
    send_cmd(OP_DFS, 7'd64, 7'd0);
    send_cmd(OP_BFS, 7'd3, 7'd0);

    repeat (70) random_cmd();

    // closing walks over the random graph
    repeat (4) send_cmd(OP_DFS, NODE_W'($urandom_range(1, NODES)), 7'd0);
    repeat (4) send_cmd(OP_BFS, NODE_W'($urandom_range(1, NODES)), 7'd0);
    send_cmd(OP_DFS, 7'd64, 7'd0);
    send_cmd(OP_BFS, 7'd1, 7'd0);

    start <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else                $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/gdbo_pkg.sv
hdl/gdbo_front.sv
hdl/gdbo_back.sv
hdl/graph_dfs_bfs_order_top.sv
tb/tb_graph_dfs_bfs_order_top.sv
